// File: rtl/mrg_pkg.sv
// ----------------------------------------------------------------------------
// mrg_pkg: shared definitions for the merge sorter
// Default sizes and the control word broadcast along the sorting chain.
// ----------------------------------------------------------------------------
package mrg_pkg;

  localparam int unsigned MaxItemsDef   = 64;
  localparam int unsigned ValueWidthDef = 32;

  // Per-cycle command to every cell of the chain
  typedef struct packed {
    logic ins;   // insert the broadcast value in order
    logic shft;  // move every entry one cell towards the head
  } cell_ctl_t;

endpackage

// File: rtl/mrg_cell.sv
// ----------------------------------------------------------------------------
// mrg_cell: one cell of the sorting chain
// Holds one value. On insert it keeps its value, takes the new value, or
// takes its upstream neighbour's value; on shift it takes the downstream one.
// ----------------------------------------------------------------------------
module mrg_cell #(
  parameter int unsigned VALUE_WIDTH = mrg_pkg::ValueWidthDef
) (
  input  logic                   clk_i,
  input  mrg_pkg::cell_ctl_t     ctl_i,
  input  logic [VALUE_WIDTH-1:0] x_i,
  input  logic                   occ_i,
  input  logic                   prev_lt_i,
  input  logic [VALUE_WIDTH-1:0] prev_val_i,
  input  logic [VALUE_WIDTH-1:0] next_val_i,
  output logic                   lt_o,
  output logic [VALUE_WIDTH-1:0] val_o
);

  logic [VALUE_WIDTH-1:0] val_q, val_d;

  // An empty cell counts as +infinity
  assign lt_o  = !occ_i || ($signed(x_i) < $signed(val_q));
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.shft) begin
      val_d = next_val_i;
    end else if (ctl_i.ins && lt_o) begin
      val_d = prev_lt_i ? prev_val_i : x_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// File: rtl/merge_sorter_top.sv
// ----------------------------------------------------------------------------
// merge_sorter_top: bounded sorter built as a systolic insertion chain
//
//   channel  | ports                                  | flow
//   ---------+----------------------------------------+---------------------
//   input    | start_i, busy_o, value_in_i, last_in_i | beat when start&!busy
//   result   | valid_o, value_out_o, last_out_o,      | one-cycle strobe,
//            | overflow_o                             | cannot be held off
//
// Each value is placed in order at the edge that accepts it, so loading runs
// at one beat a cycle. After the final beat (or a dropped beat on a full
// chain) busy_o is high while the chain shifts out one value a cycle from
// its head; each result is registered from the head cell as it shifts, and
// the last one appears as busy_o falls. Reset empties the chain at once; no
// clearing pass.
// ----------------------------------------------------------------------------
module merge_sorter_top #(
  parameter int unsigned MAX_ITEMS   = mrg_pkg::MaxItemsDef,
  parameter int unsigned VALUE_WIDTH = mrg_pkg::ValueWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [VALUE_WIDTH-1:0] value_in_i,
  input  logic                   last_in_i,
  output logic                   valid_o,
  output logic [VALUE_WIDTH-1:0] value_out_o,
  output logic                   last_out_o,
  output logic                   overflow_o
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [CW-1:0]          count_q;
  logic                   ovf_q;
  logic                   valid_q;
  logic                   last_q;
  logic [VALUE_WIDTH-1:0] value_q;

  logic                   accept;
  logic                   full;
  mrg_pkg::cell_ctl_t     ctl;

  logic [VALUE_WIDTH-1:0] val [MAX_ITEMS];
  logic                   lt  [MAX_ITEMS];
  logic                   occ [MAX_ITEMS];

  assign busy_o = (state_q == ST_EMIT);
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CW'(MAX_ITEMS));

  assign ctl.ins  = accept && !full;
  assign ctl.shft = (state_q == ST_EMIT);

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                   prev_lt;
    logic [VALUE_WIDTH-1:0] prev_val;
    logic [VALUE_WIDTH-1:0] next_val;

    assign occ[i] = (count_q > CW'(i));

    if (i == 0) begin : g_head
      assign prev_lt  = 1'b0;
      assign prev_val = '0;
    end else begin : g_body
      assign prev_lt  = lt[i-1];
      assign prev_val = val[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_val = val[i];
    end else begin : g_inner
      assign next_val = val[i+1];
    end

    mrg_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .x_i       (value_in_i),
      .occ_i     (occ[i]),
      .prev_lt_i (prev_lt),
      .prev_val_i(prev_val),
      .next_val_i(next_val),
      .lt_o      (lt[i]),
      .val_o     (val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      value_q <= '0;
    end else begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      unique case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (full) begin
              // beat dropped, sort what is held
              ovf_q   <= 1'b1;
              state_q <= ST_EMIT;
            end else begin
              count_q <= count_q + CW'(1);
              if (last_in_i) begin
                state_q <= ST_EMIT;
              end
            end
          end
        end
        ST_EMIT: begin
          valid_q <= 1'b1;
          value_q <= val[0];
          last_q  <= (count_q == CW'(1));
          count_q <= count_q - CW'(1);
          if (count_q == CW'(1)) begin
            state_q <= ST_LOAD;
            ovf_q   <= 1'b0;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // overflow is sampled with each result so its clear on the last one is safe
  logic ovf_out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_out_q <= 1'b0;
    end else if (state_q == ST_EMIT) begin
      ovf_out_q <= ovf_q;
    end
  end

  assign valid_o     = valid_q;
  assign value_out_o = value_q;
  assign last_out_o  = last_q;
  assign overflow_o  = ovf_out_q;

endmodule

// File: rtl/mrg_chk.sv
// ----------------------------------------------------------------------------
// mrg_chk: port-level checks for the merge sorter
// Run shape, ordering and flag consistency of the result beats.
// ----------------------------------------------------------------------------
module mrg_chk #(
  parameter int unsigned VALUE_WIDTH = mrg_pkg::ValueWidthDef
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   busy_o,
  input logic                   valid_o,
  input logic [VALUE_WIDTH-1:0] value_out_o,
  input logic                   last_out_o,
  input logic                   overflow_o
);

  // a run is contiguous until its last beat
  a_run_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_out_o |=> valid_o)
    else $error("result run broken before last beat");

  // results come out in ascending order
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_out_o |=> $signed(value_out_o) >= $signed($past(value_out_o)))
    else $error("results not ascending");

  // overflow flag is the same on every beat of a run
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_out_o |=> overflow_o == $past(overflow_o))
    else $error("overflow changed within a run");

  // the block frees up exactly as the last beat of a run appears
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> valid_o && last_out_o)
    else $error("busy dropped without last result");

endmodule

bind merge_sorter_top mrg_chk #(.VALUE_WIDTH(VALUE_WIDTH)) u_mrg_chk (.*);
